FILE: sv/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, defaults and the queue entry type of the k-nearest-neighbor
// search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

	localparam int COORD_W        = 16;
	localparam int INDEX_W        = 16;
	localparam int DIFF_W         = COORD_W;
	localparam int SQ_W           = 2 * DIFF_W;
	localparam int DIST_W         = 42;
	localparam int RANK_W         = 4;
	localparam int NEIGHBORS_DEF  = 10;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// one finished database vector handed from front to back
	typedef struct packed {
		logic               clear;
		logic               emit;
		logic [INDEX_W-1:0] index;
		logic [DIST_W-1:0]  distance;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: sv/knn_front.sv
// ----------------------------------------------------------------------------
// knn_front
// Takes coordinate items, forms the squared difference over two stages and
// accumulates it with saturation. Each finished vector is pushed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [knn_pkg::COORD_W-1:0]   query_coord,
	input  wire logic [knn_pkg::COORD_W-1:0]   data_coord,
	input  wire logic [knn_pkg::INDEX_W-1:0]   entry_index,
	input  wire logic                          first_of_query,
	input  wire logic                          last_coord,
	input  wire logic                          last_entry,
	input  wire logic                          q_full,
	output logic                               q_push,
	output knn_pkg::entry_t                    q_data
);

	logic                          valid_s1;
	logic [knn_pkg::DIFF_W-1:0]    diff_s1;
	logic [knn_pkg::INDEX_W-1:0]   index_s1;
	logic                          first_s1;
	logic                          end_s1;
	logic                          emit_s1;

	logic                          valid_s2;
	logic [knn_pkg::SQ_W-1:0]      sq_s2;
	logic [knn_pkg::INDEX_W-1:0]   index_s2;
	logic                          first_s2;
	logic                          end_s2;
	logic                          emit_s2;

	logic [knn_pkg::DIST_W-1:0]    acc_q;
	logic                          pend_clear_q;

	logic                          advance;
	logic signed [knn_pkg::COORD_W:0] dq;
	logic [knn_pkg::COORD_W:0]     dq_abs;
	logic [knn_pkg::DIST_W-1:0]    acc_base;
	logic [knn_pkg::DIST_W:0]      sum;
	logic [knn_pkg::DIST_W-1:0]    sum_sat;

	assign advance  = !(valid_s2 && end_s2 && q_full);
	assign in_ready = advance;

	always_comb begin
		dq     = $signed({data_coord[knn_pkg::COORD_W-1], data_coord})
		       - $signed({query_coord[knn_pkg::COORD_W-1], query_coord});
		dq_abs = dq[knn_pkg::COORD_W] ? (~dq + 1'b1) : dq;
	end

	always_comb begin
		acc_base = first_s2 ? '0 : acc_q;
		sum      = {1'b0, acc_base} + (knn_pkg::DIST_W+1)'(sq_s2);
		sum_sat  = (sum > {1'b0, knn_pkg::DIST_MAX}) ? knn_pkg::DIST_MAX
		                                              : sum[knn_pkg::DIST_W-1:0];
	end

	assign q_push = valid_s2 && end_s2 && advance;

	always_comb begin
		q_data.clear    = pend_clear_q || first_s2;
		q_data.emit     = emit_s2;
		q_data.index    = index_s2;
		q_data.distance = sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			acc_q        <= '0;
			pend_clear_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (end_s2) begin
					acc_q        <= '0;
					pend_clear_q <= 1'b0;
				end else begin
					acc_q        <= sum_sat;
					pend_clear_q <= pend_clear_q || first_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s1  <= dq_abs[knn_pkg::DIFF_W-1:0];
			index_s1 <= entry_index;
			first_s1 <= in_valid && first_of_query;
			end_s1   <= last_coord || last_entry;
			emit_s1  <= last_entry;
			sq_s2    <= diff_s1 * diff_s1;
			index_s2 <= index_s1;
			first_s2 <= first_s1;
			end_s2   <= end_s1;
			emit_s2  <= emit_s1;
		end
	end

endmodule

`default_nettype wire

FILE: sv/knn_fifo.sv
// ----------------------------------------------------------------------------
// knn_fifo
// Short register queue of finished vectors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_fifo #(
	parameter int DEPTH = knn_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire knn_pkg::entry_t  din,
	input  wire logic             pop,
	output knn_pkg::entry_t       dout,
	output logic                  empty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	knn_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) push |-> (!full || pop);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("fifo push while full");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> !empty;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("fifo pop while empty");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("fifo count out of range");

endmodule

`default_nettype wire

FILE: sv/knn_back.sv
// ----------------------------------------------------------------------------
// knn_back
// Holds the sorted neighbor list. Pops one vector a cycle while idle and the
// queue is not empty and inserts it with a parallel compare and shift; on emit
// streams the slots through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_back #(
	parameter int NEIGHBORS = knn_pkg::NEIGHBORS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire knn_pkg::entry_t               q_data,
	input  wire logic                          q_empty,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [knn_pkg::RANK_W-1:0]         neighbor_rank,
	output logic [knn_pkg::INDEX_W-1:0]        neighbor_index,
	output logic [knn_pkg::DIST_W-1:0]         squared_distance,
	output logic                               slot_valid,
	output logic                               last
);

	localparam int CNT_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} back_state_t;

	back_state_t                  state_q;
	logic [CNT_W-1:0]             cnt_q;

	logic [knn_pkg::DIST_W-1:0]   dist_q  [NEIGHBORS];
	logic [knn_pkg::INDEX_W-1:0]  index_q [NEIGHBORS];
	logic [NEIGHBORS-1:0]         valid_q;

	logic [NEIGHBORS-1:0]         valid_eff;
	logic [NEIGHBORS-1:0]         take;

	logic                         out_valid_q;
	logic [knn_pkg::RANK_W-1:0]   rank_q;
	logic [knn_pkg::INDEX_W-1:0]  out_index_q;
	logic [knn_pkg::DIST_W-1:0]   out_dist_q;
	logic                         out_slot_valid_q;
	logic                         out_last_q;

	logic                         load;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// a cleared list is all empty, so the new vector lands in slot 0
	always_comb begin
		valid_eff = q_data.clear ? '0 : valid_q;
		for (int i = 0; i < NEIGHBORS; i++) begin
			take[i] = !valid_eff[i] || (q_data.distance < dist_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (q_pop) begin
			if (take[0]) begin
				valid_q[0] <= 1'b1;
			end
			for (int i = 1; i < NEIGHBORS; i++) begin
				if (take[i]) begin
					valid_q[i] <= take[i-1] ? valid_eff[i-1] : 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (take[0]) begin
				dist_q[0]  <= q_data.distance;
				index_q[0] <= q_data.index;
			end
			for (int i = 1; i < NEIGHBORS; i++) begin
				if (take[i]) begin
					if (take[i-1]) begin
						dist_q[i]  <= dist_q[i-1];
						index_q[i] <= index_q[i-1];
					end else begin
						dist_q[i]  <= q_data.distance;
						index_q[i] <= q_data.index;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_pop && q_data.emit) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (cnt_q == CNT_W'(NEIGHBORS - 1)) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rank_q           <= knn_pkg::RANK_W'(cnt_q);
			out_index_q      <= valid_q[cnt_q] ? index_q[cnt_q] : '0;
			out_dist_q       <= valid_q[cnt_q] ? dist_q[cnt_q] : '0;
			out_slot_valid_q <= valid_q[cnt_q];
			out_last_q       <= (cnt_q == CNT_W'(NEIGHBORS - 1));
		end
	end

	assign out_valid        = out_valid_q;
	assign neighbor_rank    = rank_q;
	assign neighbor_index   = out_index_q;
	assign squared_distance = out_dist_q;
	assign slot_valid       = out_slot_valid_q;
	assign last             = out_last_q;

	property p_valid_prefix;
		@(posedge clk) disable iff (!arst_n)
			((valid_q >> 1) & ~valid_q) == '0;
	endproperty
	a_valid_prefix: assert property (p_valid_prefix) else $error("hole in neighbor list");

	property p_idle_cnt;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_IDLE) |=> (cnt_q == '0);
	endproperty
	a_idle_cnt: assert property (p_idle_cnt) else $error("slot counter not reset");

	property p_emit_entry;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_IDLE && q_pop && q_data.emit) |=> (state_q == ST_EMIT);
	endproperty
	a_emit_entry: assert property (p_emit_entry) else $error("emit not started");

endmodule

`default_nettype wire

FILE: sv/knn_top_k_search_unit.sv
// ----------------------------------------------------------------------------
// knn_top_k_search_unit
// Brute-force k-nearest-neighbor search on squared Euclidean distance with a
// sorted top-K list; front accumulates, back inserts and emits.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_ready  | query_coord, data_coord, entry_index,
//           |                    | first_of_query, last_coord, last_entry
//  out      | out_valid/out_ready| neighbor_rank, neighbor_index,
//           |                    | squared_distance, slot_valid, last
//
//  One coordinate item per cycle while in_ready is high, through front stages
//  s1 and s2. The back inserts each finished vector on its pop; an emit holds
//  the back for the NEIGHBORS slots, one slot a cycle while out_ready is high,
//  while the queue of QUEUE_DEPTH vectors keeps the front running.
//  The front stalls only when a finished vector meets a full queue.
//  Reset empties the list, the accumulator and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_top_k_search_unit #(
	parameter int NEIGHBORS   = knn_pkg::NEIGHBORS_DEF,
	parameter int QUEUE_DEPTH = knn_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [knn_pkg::COORD_W-1:0]   query_coord,
	input  wire logic [knn_pkg::COORD_W-1:0]   data_coord,
	input  wire logic [knn_pkg::INDEX_W-1:0]   entry_index,
	input  wire logic                          first_of_query,
	input  wire logic                          last_coord,
	input  wire logic                          last_entry,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [knn_pkg::RANK_W-1:0]         neighbor_rank,
	output logic [knn_pkg::INDEX_W-1:0]        neighbor_index,
	output logic [knn_pkg::DIST_W-1:0]         squared_distance,
	output logic                               slot_valid,
	output logic                               last
);

	knn_pkg::entry_t push_data;
	knn_pkg::entry_t pop_data;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	knn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.query_coord    (query_coord),
		.data_coord     (data_coord),
		.entry_index    (entry_index),
		.first_of_query (first_of_query),
		.last_coord     (last_coord),
		.last_entry     (last_entry),
		.q_full         (q_full),
		.q_push         (push),
		.q_data         (push_data)
	);

	knn_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (pop_data),
		.empty  (q_empty),
		.full   (q_full)
	);

	knn_back #(
		.NEIGHBORS (NEIGHBORS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_data           (pop_data),
		.q_empty          (q_empty),
		.q_pop            (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.neighbor_rank    (neighbor_rank),
		.neighbor_index   (neighbor_index),
		.squared_distance (squared_distance),
		.slot_valid       (slot_valid),
		.last             (last)
	);

endmodule

`default_nettype wire

FILE: sim/tb_knn_top_k_search_unit.sv
// ----------------------------------------------------------------------------
// tb_knn_top_k_search_unit
// Drives coordinate items into the k-nearest-neighbor search unit and tracks
// the squared distances and the sorted neighbor list on the side. Every
// emitted slot is checked field by field against the tracked list. Directed
// queries cover extremes, ties, list overflow and a restart in mid-vector;
// random queries with random stalls on both sides follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_knn_top_k_search_unit;

	localparam int COORD_W      = knn_pkg::COORD_W;
	localparam int INDEX_W      = knn_pkg::INDEX_W;
	localparam int DIST_W       = knn_pkg::DIST_W;
	localparam int RANK_W       = knn_pkg::RANK_W;
	localparam int NEIGHBORS    = knn_pkg::NEIGHBORS_DEF;
	localparam int RANDOM_ITEMS = 90;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [DIST_W:0] SAT_LIMIT = {1'b0, knn_pkg::DIST_MAX};

	typedef struct packed {
		logic [RANK_W-1:0]  rank;
		logic [INDEX_W-1:0] index;
		logic [DIST_W-1:0]  distance;
		logic               valid;
		logic               is_last;
	} slot_result_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [COORD_W-1:0]  query_coord    = '0;
	logic [COORD_W-1:0]  data_coord     = '0;
	logic [INDEX_W-1:0]  entry_index    = '0;
	logic                first_of_query = 1'b0;
	logic                last_coord     = 1'b0;
	logic                last_entry     = 1'b0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [RANK_W-1:0]   neighbor_rank;
	logic [INDEX_W-1:0]  neighbor_index;
	logic [DIST_W-1:0]   squared_distance;
	logic                slot_valid;
	logic                last;

	// tracked state of the search
	logic [DIST_W:0]     acc_dist;
	logic [DIST_W:0]     list_dist  [NEIGHBORS];
	logic [INDEX_W-1:0]  list_index [NEIGHBORS];
	logic                list_valid [NEIGHBORS];

	slot_result_t        pending_slots[$];
	int                  mismatches  = 0;
	int                  cycle_count = 0;
	bit                  steady      = 1'b0;

	knn_top_k_search_unit #(
		.NEIGHBORS(NEIGHBORS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.query_coord(query_coord),
		.data_coord(data_coord),
		.entry_index(entry_index),
		.first_of_query(first_of_query),
		.last_coord(last_coord),
		.last_entry(last_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.neighbor_rank(neighbor_rank),
		.neighbor_index(neighbor_index),
		.squared_distance(squared_distance),
		.slot_valid(slot_valid),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit idle_roll();
		return !steady && ($urandom_range(99) < 33);
	endfunction

	function automatic void clear_neighbor_list();
		for (int i = 0; i < NEIGHBORS; i++) begin
			list_dist[i]  = '1;
			list_index[i] = '0;
			list_valid[i] = 1'b0;
		end
	endfunction

	// accumulate one coordinate, insert finished vectors, queue emitted slots
	function automatic void track_coordinate(shortint q, shortint d, logic [INDEX_W-1:0] idx,
			bit first, bit lc, bit le);
		int              qv;
		int              dv;
		int              pos;
		logic [DIST_W:0] diff_mag;
		logic [DIST_W:0] diff_sq;
		slot_result_t    slot;
		qv = q;
		dv = d;
		if (first) begin
			clear_neighbor_list();
			acc_dist = '0;
		end
		diff_mag = (DIST_W+1)'((dv >= qv) ? (dv - qv) : (qv - dv));
		diff_sq  = diff_mag * diff_mag;
		if (acc_dist > SAT_LIMIT || diff_sq > SAT_LIMIT - acc_dist)
			acc_dist = SAT_LIMIT;
		else
			acc_dist = acc_dist + diff_sq;
		if (lc || le) begin
			pos = NEIGHBORS;
			for (int i = 0; i < NEIGHBORS; i++)
				if (pos == NEIGHBORS && (!list_valid[i] || acc_dist < list_dist[i]))
					pos = i;
			if (pos < NEIGHBORS) begin
				for (int j = NEIGHBORS - 1; j > pos; j--) begin
					list_dist[j]  = list_dist[j-1];
					list_index[j] = list_index[j-1];
					list_valid[j] = list_valid[j-1];
				end
				list_dist[pos]  = acc_dist;
				list_index[pos] = idx;
				list_valid[pos] = 1'b1;
			end
			acc_dist = '0;
		end
		if (le) begin
			for (int i = 0; i < NEIGHBORS; i++) begin
				slot.rank     = i[RANK_W-1:0];
				slot.index    = list_valid[i] ? list_index[i] : '0;
				slot.distance = list_valid[i] ? list_dist[i][DIST_W-1:0] : '0;
				slot.valid    = list_valid[i];
				slot.is_last  = (i == NEIGHBORS - 1);
				pending_slots.push_back(slot);
			end
		end
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(shortint q, shortint d, logic [INDEX_W-1:0] idx,
			bit first, bit lc, bit le);
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		query_coord    <= q;
		data_coord     <= d;
		entry_index    <= idx;
		first_of_query <= first;
		last_coord     <= lc;
		last_entry     <= le;
		do @(posedge clk); while (!in_ready);
		track_coordinate(q, d, idx, first, lc, le);
		@(negedge clk);
	endtask

	// extreme differences, a tie, a partly filled list, list kept after emit
	task automatic test_ties_and_extremes();
		send_item(-32768, 32767, 16'hFFFF, 1, 1, 0);
		send_item(32767, -32768, 16'h0000, 0, 0, 0);
		send_item(0, 0, 16'h0000, 0, 1, 0);
		send_item(100, 100, 16'h0005, 0, 1, 0);
		send_item(-1, 1, 16'h0007, 0, 0, 1);
		send_item(3, 5, 16'h00AA, 0, 1, 1);
	endtask

	// more vectors than slots, with ties; the largest fall off
	task automatic test_list_overflow();
		shortint dvals[12] = '{9, 3, 9, 1, 12, 3, 0, 5, 7, 2, 3, 8};
		for (int i = 0; i < 12; i++)
			send_item(0, dvals[i], 16'h0100 + i[INDEX_W-1:0], i == 0, 1, i == 11);
	endtask

	// one-item query, and a new query starting in the middle of a vector
	task automatic test_query_restart();
		send_item(7, -7, 16'h1234, 1, 1, 1);
		send_item(1000, 0, 16'h0003, 0, 0, 0);
		send_item(2, 0, 16'h0009, 1, 1, 1);
	endtask

	task automatic test_random_queries();
		int      sent;
		int      nvec;
		int      len;
		int      mode;
		shortint q;
		shortint d;
		shortint corner[4] = '{-32768, 32767, 0, -1};
		logic [INDEX_W-1:0] idx;
		bit      first;
		bit      lc;
		bit      le;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (sent == 0) || ($urandom_range(4) == 0);
			nvec   = $urandom_range(14, 1);
			mode   = $urandom_range(2);
			for (int v = 0; v < nvec; v++) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
				idx = INDEX_W'($urandom);
				for (int c = 0; c < len; c++) begin
					case (mode)
						0: begin
							q = 16'($urandom);
							d = 16'($urandom);
						end
						1: begin
							q = 16'($urandom_range(3));
							d = 16'($urandom_range(3));
						end
						default: begin
							q = corner[$urandom_range(3)];
							d = corner[$urandom_range(3)];
						end
					endcase
					first = (v == 0 && c == 0);
					lc    = (c == len - 1);
					le    = (v == nvec - 1 && c == len - 1);
					// broken sequences: flags at random
					if ($urandom_range(19) == 0) begin
						first = 1'($urandom);
						lc    = 1'($urandom);
						le    = 1'($urandom);
					end
					send_item(q, d, idx, first, lc, le);
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99) >= 33);

	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_slots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected slot: rank %0d index %h dist %h valid %b last %b",
						neighbor_rank, neighbor_index, squared_distance, slot_valid, last);
			end else begin
				want = pending_slots.pop_front();
				if (neighbor_rank !== want.rank || neighbor_index !== want.index ||
						squared_distance !== want.distance || slot_valid !== want.valid ||
						last !== want.is_last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("slot mismatch: exp rank %0d index %h dist %h valid %b last %b",
							want.rank, want.index, want.distance, want.valid, want.is_last);
						$display("               got rank %0d index %h dist %h valid %b last %b",
							neighbor_rank, neighbor_index, squared_distance, slot_valid,
							last);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_knn_top_k_search_unit NOT OK");
		$finish;
	end

	initial begin
		acc_dist = '0;
		clear_neighbor_list();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_ties_and_extremes();
		test_list_overflow();
		test_query_restart();
		test_random_queries();
		in_valid <= 1'b0;
		while (pending_slots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_slots.size() == 0)
			$display("tb_knn_top_k_search_unit OK");
		else
			$display("tb_knn_top_k_search_unit NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
